/* rtl/core/cct_rgb_light_mixer_unit_macros.svh */
// assertion macros for the light mixer unit
`ifndef CCT_RGB_LIGHT_MIXER_UNIT_MACROS_SVH
`define CCT_RGB_LIGHT_MIXER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crlm assertion failed");

// next-cycle implication, checked outside reset
`define CRLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crlm assertion failed");

`endif

/* rtl/core/crlm_pkg.sv */
// shared types, command codes and divider operation codes
`timescale 1ns / 1ps
package crlm_pkg;

  localparam logic [3:0] CMD_MASTER    = 4'd0;
  localparam logic [3:0] CMD_WHITE_EN  = 4'd1;
  localparam logic [3:0] CMD_WHITE_DIM = 4'd2;
  localparam logic [3:0] CMD_KELVIN    = 4'd3;
  localparam logic [3:0] CMD_MIRED     = 4'd4;
  localparam logic [3:0] CMD_RGB_EN    = 4'd5;
  localparam logic [3:0] CMD_RGB_DIM   = 4'd6;
  localparam logic [3:0] CMD_COLOR     = 4'd7;
  localparam logic [3:0] CMD_REFRESH   = 4'd8;

  localparam logic [2:0] OP_MIRED = 3'd0;
  localparam logic [2:0] OP_COLD  = 3'd1;
  localparam logic [2:0] OP_RED   = 3'd2;
  localparam logic [2:0] OP_GREEN = 3'd3;
  localparam logic [2:0] OP_BLUE  = 3'd4;

  typedef struct packed {
    logic       capture;
    logic       update;
    logic       bad_arg;
    logic       off_result;
    logic       white_wr;
    logic       rgb_wr;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [2:0] op;
    logic       out_load;
  } crlm_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       has_value;
    logic       onoff;
    logic       ready;
    logic       master_on;
    logic       white_go;
    logic       rgb_go;
    logic       out_free;
  } crlm_stat_t;

endpackage

/* rtl/core/crlm_in_if.sv */
// command channel: valid/ready plus one command word
`timescale 1ns / 1ps
interface crlm_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic               has_value;
  logic signed [16:0] value;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic               strip_ready;

  modport source (
    output valid, cmd, has_value, value, red_in, green_in, blue_in, strip_ready,
    input  ready
  );
  modport sink (
    input  valid, cmd, has_value, value, red_in, green_in, blue_in, strip_ready,
    output ready
  );
endinterface

/* rtl/core/crlm_out_if.sv */
// result channel: valid/ready plus one result word
`timescale 1ns / 1ps
interface crlm_out_if;
  logic       valid;
  logic       ready;
  logic       white_write;
  logic [6:0] cold_level;
  logic [6:0] warm_level;
  logic       rgb_write;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       status;

  modport source (
    output valid, white_write, cold_level, warm_level, rgb_write,
           red_out, green_out, blue_out, status,
    input  ready
  );
  modport sink (
    input  valid, white_write, cold_level, warm_level, rgb_write,
           red_out, green_out, blue_out, status,
    output ready
  );
endinterface

/* rtl/core/crlm_datapath.sv */
// light state, shared multiplier, reciprocal scaling, mired divider, result and output registers
`timescale 1ns / 1ps
module crlm_datapath
  import crlm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  crlm_in_if.sink    req,
  crlm_out_if.source rsp,
  input  crlm_cmd_t  ctl,
  output crlm_stat_t stat
);

  localparam int DIV_W = 20;
  localparam int REM_W = 13;
  localparam logic [DIV_W-1:0] MIRED_NUM = 20'd1000000;
  localparam logic [12:0]      K_MIN     = 13'd2000;
  // ceil(2^31 / 4500), exact for products up to 4500 * 100
  localparam logic [18:0]      COLD_RECIP = 19'd477219;
  // ceil(2^19 / 100), exact for products up to 255 * 100
  localparam logic [12:0]      PCT_RECIP  = 13'd5243;

  function automatic logic [6:0] clamp_pct(input logic signed [16:0] v);
    if (v < 17'sd0) return 7'd0;
    if (v > 17'sd100) return 7'd100;
    return v[6:0];
  endfunction

  function automatic logic [12:0] clamp_kelvin(input logic signed [16:0] v);
    if (v < 17'sd2000) return 13'd2000;
    if (v > 17'sd6500) return 13'd6500;
    return v[12:0];
  endfunction

  function automatic logic [12:0] clamp_mired(input logic signed [16:0] v);
    if (v < 17'sd154) return 13'd154;
    if (v > 17'sd500) return 13'd500;
    return v[12:0];
  endfunction

  // captured command word
  logic [3:0]         cmd_q;
  logic               has_q;
  logic signed [16:0] val_q;
  logic [7:0]         red_q, green_q, blue_q;
  logic               ready_q;

  // light state
  logic        master_on, white_on, rgb_on;
  logic [6:0]  white_level, rgb_level;
  logic [12:0] kelvin;
  logic [7:0]  stored_red, stored_green, stored_blue;

  // result under construction
  logic       res_white_write, res_rgb_write, res_status;
  logic [6:0] res_cold, res_warm;
  logic [7:0] res_red, res_green, res_blue;

  // divider
  logic [DIV_W-1:0] dq;
  logic [REM_W-1:0] rem;
  logic [12:0]      dvs;

  logic             onoff;
  logic [12:0]      mul_a;
  logic [6:0]       mul_b;
  logic [DIV_W-1:0] prod;
  logic [REM_W:0]   s1, s2, d1, d2;
  logic             ge1, ge2;
  logic [REM_W-1:0] r1, r2;
  logic             out_valid;

  // constant divisions by reciprocal multiply on the registered product
  logic [37:0]      cold_prod;
  logic [26:0]      pct_prod;
  logic [6:0]       cold_q;
  logic [7:0]       pct_q;

  assign onoff = has_q ? (val_q != 17'sd0) : 1'b1;

  always_comb begin
    mul_a = kelvin - K_MIN;
    mul_b = white_level;
    case (ctl.op)
      OP_RED: begin
        mul_a = {5'd0, stored_red};
        mul_b = rgb_level;
      end
      OP_GREEN: begin
        mul_a = {5'd0, stored_green};
        mul_b = rgb_level;
      end
      OP_BLUE: begin
        mul_a = {5'd0, stored_blue};
        mul_b = rgb_level;
      end
      default: begin
        mul_a = kelvin - K_MIN;
        mul_b = white_level;
      end
    endcase
  end

  assign prod = {7'd0, mul_a} * {13'd0, mul_b};

  assign cold_prod = {19'd0, dq[18:0]} * {19'd0, COLD_RECIP};
  assign cold_q    = cold_prod[37:31];
  assign pct_prod  = {12'd0, dq[14:0]} * {14'd0, PCT_RECIP};
  assign pct_q     = pct_prod[26:19];

  // two restoring steps per cycle
  always_comb begin
    s1  = {rem, dq[DIV_W-1]};
    d1  = {1'b0, dvs};
    ge1 = (s1 >= d1);
    r1  = ge1 ? REM_W'(s1 - d1) : s1[REM_W-1:0];
    s2  = {r1, dq[DIV_W-2]};
    d2  = {1'b0, dvs};
    ge2 = (s2 >= d2);
    r2  = ge2 ? REM_W'(s2 - d2) : s2[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= req.cmd;
      has_q   <= req.has_value;
      val_q   <= req.value;
      red_q   <= req.red_in;
      green_q <= req.green_in;
      blue_q  <= req.blue_in;
      ready_q <= req.strip_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_on    <= 1'b0;
      white_on     <= 1'b1;
      white_level  <= 7'd100;
      kelvin       <= 13'd4201;
      rgb_on       <= 1'b0;
      rgb_level    <= 7'd100;
      stored_red   <= 8'd255;
      stored_green <= 8'd0;
      stored_blue  <= 8'd0;
    end else begin
      if (ctl.update) begin
        case (cmd_q)
          CMD_MASTER:    master_on <= onoff;
          CMD_WHITE_EN:  white_on <= onoff;
          CMD_WHITE_DIM: if (has_q) white_level <= clamp_pct(val_q);
          CMD_KELVIN:    if (has_q) kelvin <= clamp_kelvin(val_q);
          CMD_RGB_EN:    rgb_on <= onoff;
          CMD_RGB_DIM:   if (has_q) rgb_level <= clamp_pct(val_q);
          CMD_COLOR: begin
            stored_red   <= red_q;
            stored_green <= green_q;
            stored_blue  <= blue_q;
          end
          default: ;
        endcase
      end
      // quotient is always inside 2000..6493, no clamp needed
      if (ctl.div_store && ctl.op == OP_MIRED) kelvin <= dq[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      res_white_write <= 1'b0;
      res_rgb_write   <= 1'b0;
      res_status      <= 1'b0;
      res_cold        <= 7'd0;
      res_warm        <= 7'd0;
      res_red         <= 8'd0;
      res_green       <= 8'd0;
      res_blue        <= 8'd0;
    end else begin
      if (ctl.bad_arg) res_status <= 1'b1;
      if (ctl.off_result) begin
        res_white_write <= 1'b1;
        res_rgb_write   <= ready_q;
      end
      if (ctl.white_wr) res_white_write <= 1'b1;
      if (ctl.rgb_wr) res_rgb_write <= 1'b1;
      if (ctl.div_store) begin
        case (ctl.op)
          OP_COLD: begin
            res_cold <= cold_q;
            res_warm <= white_level - cold_q;
          end
          OP_RED:   res_red <= pct_q;
          OP_GREEN: res_green <= pct_q;
          OP_BLUE:  res_blue <= pct_q;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem <= '0;
      if (ctl.op == OP_MIRED) begin
        dq  <= MIRED_NUM;
        dvs <= clamp_mired(val_q);
      end else begin
        dq <= prod;
      end
    end else if (ctl.div_step) begin
      rem <= r2;
      dq  <= {dq[DIV_W-3:0], ge1, ge2};
    end
  end

  // output register, frees the core while a word waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.white_write <= res_white_write;
      rsp.cold_level  <= res_cold;
      rsp.warm_level  <= res_warm;
      rsp.rgb_write   <= res_rgb_write;
      rsp.red_out     <= res_red;
      rsp.green_out   <= res_green;
      rsp.blue_out    <= res_blue;
      rsp.status      <= res_status;
    end
  end

  assign rsp.valid = out_valid;

  assign stat.cmd       = cmd_q;
  assign stat.has_value = has_q;
  assign stat.onoff     = onoff;
  assign stat.ready     = ready_q;
  assign stat.master_on = master_on;
  assign stat.white_go  = white_on && (white_level != 7'd0);
  assign stat.rgb_go    = rgb_on && (rgb_level != 7'd0);
  assign stat.out_free  = !out_valid || rsp.ready;

endmodule

/* rtl/core/crlm_ctrl.sv */
// command sequencer: decode, white and rgb branches, divider scheduling
`timescale 1ns / 1ps
module crlm_ctrl
  import crlm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  crlm_stat_t stat,
  output crlm_cmd_t  ctl
);

  localparam int DIV_STEPS = 10;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WHITE  = 3'd2;
  localparam logic [2:0] S_RGB    = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_ITER   = 3'd5;
  localparam logic [2:0] S_STORE  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]       state, state_next;
  logic [2:0]       op, op_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [2:0]       after_white;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_MIRED;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
    end
  end

  // master-on walks on to the strip after the white pair
  assign after_white = (stat.cmd == CMD_MASTER) ? S_RGB : S_FINISH;

  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    ctl        = '0;
    ctl.op     = op;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.update = 1'b1;
        case (stat.cmd)
          CMD_MASTER: begin
            if (stat.onoff) begin
              state_next = S_WHITE;
            end else begin
              ctl.off_result = 1'b1;
              state_next     = S_FINISH;
            end
          end
          CMD_WHITE_EN, CMD_WHITE_DIM: state_next = S_WHITE;
          CMD_KELVIN: begin
            if (stat.has_value) begin
              state_next = S_WHITE;
            end else begin
              ctl.bad_arg = 1'b1;
              state_next  = S_FINISH;
            end
          end
          CMD_MIRED: begin
            if (stat.has_value) begin
              op_next    = OP_MIRED;
              state_next = S_LOAD;
            end else begin
              ctl.bad_arg = 1'b1;
              state_next  = S_FINISH;
            end
          end
          CMD_RGB_EN, CMD_RGB_DIM, CMD_COLOR, CMD_REFRESH: state_next = S_RGB;
          default: state_next = S_FINISH;
        endcase
      end
      S_WHITE: begin
        if (stat.master_on) begin
          ctl.white_wr = 1'b1;
          if (stat.white_go) begin
            op_next    = OP_COLD;
            state_next = S_LOAD;
          end else begin
            state_next = after_white;
          end
        end else begin
          state_next = after_white;
        end
      end
      S_RGB: begin
        if (stat.master_on && stat.ready) begin
          ctl.rgb_wr = 1'b1;
          if (stat.rgb_go) begin
            op_next    = OP_RED;
            state_next = S_LOAD;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_LOAD: begin
        ctl.div_load = 1'b1;
        // only the mired conversion needs the iterative divider
        if (op == OP_MIRED) begin
          cnt_next   = CNT_W'(DIV_STEPS - 1);
          state_next = S_ITER;
        end else begin
          state_next = S_STORE;
        end
      end
      S_ITER: begin
        ctl.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_STORE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_STORE: begin
        ctl.div_store = 1'b1;
        case (op)
          OP_MIRED: state_next = S_WHITE;
          OP_COLD:  state_next = after_white;
          OP_RED: begin
            op_next    = OP_GREEN;
            state_next = S_LOAD;
          end
          OP_GREEN: begin
            op_next    = OP_BLUE;
            state_next = S_LOAD;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/cct_rgb_light_mixer_unit.sv */
// light mixer top level: sequencer plus datapath behind valid/ready channels
//
//   channel  dir  handshake     word
//   req      in   valid/ready   cmd, has_value, value, red_in, green_in, blue_in, strip_ready
//   rsp      out  valid/ready   white_write, cold/warm level, rgb_write, rgb out, status
//
// one command at a time; an accepted word runs decode and its branch states before the output register
// mired conversion holds the radix-4 divider through load, ten two-bit steps and store
// cold split and each color byte use the product register, then the reciprocal multiply
// mired with the white pair lit is the longest command, ahead of master-on with both lit
// rst is synchronous and restores the power-up light state
// req.ready is high whenever the sequencer is idle, also while a result waits in rsp
`timescale 1ns / 1ps
`include "cct_rgb_light_mixer_unit_macros.svh"
module cct_rgb_light_mixer_unit
  import crlm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  crlm_in_if.sink    req,
  crlm_out_if.source rsp
);

  crlm_cmd_t  ctl;
  crlm_stat_t stat;
  logic       ctl_ready;

  crlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ctl_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  crlm_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .ctl  (ctl),
    .stat (stat)
  );

  assign req.ready = ctl_ready;

  `CRLM_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `CRLM_ASSERT_NOW(a_bad_arg_no_write, rsp.valid && rsp.status, !rsp.white_write && !rsp.rgb_write)
  `CRLM_ASSERT_NOW(a_white_idle_zero, rsp.valid && !rsp.white_write, rsp.cold_level == 7'd0 && rsp.warm_level == 7'd0)
  `CRLM_ASSERT_NOW(a_white_sum, rsp.valid, ({1'b0, rsp.cold_level} + {1'b0, rsp.warm_level}) <= 8'd100)

endmodule
